FILE: src/bmpu_pkg.sv
// shared types and constants for the integer bmp upscaler
`timescale 1ns / 1ps

package bmpu_pkg;

   localparam int FACTOR_W     = 6;
   localparam int WIDTH_W      = 13;
   localparam int PAD_W        = 2;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 13;
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_FACTOR = 60;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_FACTOR = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SOURCE_WIDTH = 1'b1;

   localparam logic PIX_KIND_PIXEL = 1'b0;
   localparam logic PIX_KIND_PAD   = 1'b1;
   localparam logic REQ_KIND_PIXEL = 1'b0;
   localparam logic REQ_KIND_TICK  = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one run handed to the emitter: a pixel repeated, then padding
   typedef struct packed {
      pixel_type           px;
      logic                ends;
      logic [FACTOR_W-1:0] factor;
      logic [PAD_W-1:0]    pad;
   } run_cmd_type;

endpackage

FILE: src/bmpu_line_buf.sv
// line buffer: one-write one-read synchronous memory of source pixels
`timescale 1ns / 1ps

module bmpu_line_buf #(
   parameter int DEPTH = bmpu_pkg::DEF_MAX_WIDTH,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  bmpu_pkg::pixel_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output bmpu_pkg::pixel_type rd_data
);
   import bmpu_pkg::*;

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bmpu_emitter.sv
// run emitter: repeats one pixel factor times, adds row padding, drives the result register
`timescale 1ns / 1ps

module bmpu_emitter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  bmpu_pkg::run_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // blue, green, red
   output logic [1:0]            rsp_tuser,   // out_kind, row_end
   output logic                  rsp_tlast
);
   import bmpu_pkg::*;

   logic                busy_ff, busy_in;
   pixel_type           px_ff, px_in;
   logic                ends_ff, ends_in;
   logic [FACTOR_W-1:0] rep_ff, rep_in;
   logic [PAD_W-1:0]    pad_ff, pad_in;

   logic                valid_ff, valid_in;
   pixel_type           data_ff, data_in;
   logic                kind_ff, kind_in;
   logic                rend_ff, rend_in;
   logic                last_ff, last_in;

   logic                adv;

   assign adv = busy_ff && (!valid_ff || rsp_tready);

   always_comb begin
      busy_in  = busy_ff;
      px_in    = px_ff;
      ends_in  = ends_ff;
      rep_in   = rep_ff;
      pad_in   = pad_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      kind_in  = kind_ff;
      rend_in  = rend_ff;
      last_in  = last_ff;
      if (start) begin
         busy_in = 1'b1;
         px_in   = cmd.px;
         ends_in = cmd.ends;
         rep_in  = cmd.factor;
         pad_in  = cmd.ends ? cmd.pad : '0;
      end else if (adv) begin
         valid_in = 1'b1;
         if (rep_ff != '0) begin
            rep_in  = rep_ff - 1'b1;
            data_in = px_ff;
            kind_in = PIX_KIND_PIXEL;
            if (rep_ff == FACTOR_W'(1) && pad_ff == '0) begin
               rend_in = ends_ff;
               last_in = 1'b1;
               busy_in = 1'b0;
            end else begin
               rend_in = 1'b0;
               last_in = 1'b0;
            end
         end else begin
            pad_in  = pad_ff - 1'b1;
            data_in = '0;
            kind_in = PIX_KIND_PAD;
            rend_in = (pad_ff == PAD_W'(1));
            last_in = (pad_ff == PAD_W'(1));
            busy_in = (pad_ff != PAD_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      px_ff   <= px_in;
      ends_ff <= ends_in;
      rep_ff  <= rep_in;
      pad_ff  <= pad_in;
      data_ff <= data_in;
      kind_ff <= kind_in;
      rend_ff <= rend_in;
      last_ff <= last_in;
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {rend_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule

FILE: src/bmp_integer_upscaler.sv
// top level of the nearest-neighbor integer upscaler for 24-bit bmp rows
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata blue,green,red; tuser kind
//   rsp      out        rsp_tvalid/rsp_tready  tdata blue,green,red; tuser out_kind,row_end;
//                                              tlast last
//   csr      in         csr_we                 csr_addr index, csr_wdata value
//
// one request at a time; a pixel gives factor results, plus up to three padding
// bytes when it ends a row, at one result per cycle while rsp does not stall
// a replay tick first reads its pixel from the line buffer, then emits it the same way
// a tick outside a replay is accepted and has no effect; stalls on rsp hold the results
// reset clears the column counters and replay passes; the line buffer is not cleared
`timescale 1ns / 1ps

module bmp_integer_upscaler #(
   parameter int MAX_WIDTH  = bmpu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_FACTOR = bmpu_pkg::DEF_MAX_FACTOR
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,   // blue, green, red
   input  logic                                req_tuser,   // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,   // blue, green, red
   output logic [1:0]                          rsp_tuser,   // out_kind, row_end
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [bmpu_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bmpu_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bmpu_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [CW-1:0]       wcol_ff, wcol_in;
   logic [CW-1:0]       rcol_ff, rcol_in;
   logic [FACTOR_W-1:0] passes_ff, passes_in;
   logic                rend_ff, rend_in;

   logic [FACTOR_W-1:0] eff_factor;
   logic [WIDTH_W-1:0]  eff_width;
   logic [3:0]          pad_prod;
   logic [PAD_W-1:0]    pad_cnt;
   logic                accept;
   logic                is_pixel;
   logic                wr_ends;
   logic                rd_ends;
   logic                rd_en;
   logic                run_busy;
   logic                run_start;
   run_cmd_type         run_cmd;
   pixel_type           in_px;
   pixel_type           rd_px;

   // clamp the registers to their usable range
   always_comb begin
      eff_factor = factor_ff;
      if (factor_ff == '0) begin
         eff_factor = FACTOR_W'(1);
      end else if (32'(factor_ff) > 32'(MAX_FACTOR)) begin
         eff_factor = FACTOR_W'(MAX_FACTOR);
      end
      eff_width = width_ff;
      if (width_ff == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = WIDTH_W'(MAX_WIDTH);
      end
   end

   // padding bytes = (width * factor) mod 4, since 3 * bytes per pixel wraps that way
   assign pad_prod = {2'b00, eff_width[1:0]} * {2'b00, eff_factor[1:0]};
   assign pad_cnt  = pad_prod[1:0];

   assign in_px      = req_tdata;
   assign req_tready = (state_ff == ST_IDLE) && !run_busy;
   assign accept     = req_tvalid && req_tready;
   assign is_pixel   = (req_tuser == REQ_KIND_PIXEL);
   assign wr_ends    = (32'(wcol_ff) + 32'd1) >= 32'(eff_width);
   assign rd_ends    = (32'(rcol_ff) + 32'd1) >= 32'(eff_width);
   assign rd_en      = accept && !is_pixel && (passes_ff != '0);

   always_comb begin
      state_in  = state_ff;
      wcol_in   = wcol_ff;
      rcol_in   = rcol_ff;
      passes_in = passes_ff;
      rend_in   = rend_ff;
      run_start = 1'b0;
      run_cmd   = '{px: in_px, ends: wr_ends, factor: eff_factor, pad: pad_cnt};
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_pixel) begin
               run_start = 1'b1;
               if (wr_ends) begin
                  wcol_in   = '0;
                  rcol_in   = '0;
                  passes_in = eff_factor - 1'b1;
               end else begin
                  wcol_in = wcol_ff + 1'b1;
               end
            end else if (rd_en) begin
               rend_in  = rd_ends;
               state_in = ST_READ;
               if (rd_ends) begin
                  rcol_in   = '0;
                  passes_in = passes_ff - 1'b1;
               end else begin
                  rcol_in = rcol_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            // buffered pixel is on the read port now
            run_start = 1'b1;
            run_cmd   = '{px: rd_px, ends: rend_ff, factor: eff_factor, pad: pad_cnt};
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      factor_in = factor_ff;
      width_in  = width_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SCALE_FACTOR: factor_in = csr_wdata[FACTOR_W-1:0];
            CSR_SOURCE_WIDTH: width_in  = csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         factor_ff <= FACTOR_W'(1);
         width_ff  <= WIDTH_W'(1);
         wcol_ff   <= '0;
         rcol_ff   <= '0;
         passes_ff <= '0;
      end else begin
         state_ff  <= state_in;
         factor_ff <= factor_in;
         width_ff  <= width_in;
         wcol_ff   <= wcol_in;
         rcol_ff   <= rcol_in;
         passes_ff <= passes_in;
      end
      rend_ff <= rend_in;
   end

   bmpu_line_buf #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept && is_pixel),
      .wr_addr (wcol_ff),
      .wr_data (in_px),
      .rd_en   (rd_en),
      .rd_addr (rcol_ff),
      .rd_data (rd_px)
   );

   bmpu_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .start      (run_start),
      .cmd        (run_cmd),
      .busy       (run_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
